@@ sv/uri_percent_decoder_core_assert.svh @@
// Assertion macros for the URI percent decoder core
`ifndef URI_PERCENT_DECODER_CORE_ASSERT_SVH
`define URI_PERCENT_DECODER_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define UPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define UPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/upd_pkg.sv @@
// Shared types, constants and helper functions of the URI percent decoder
`default_nettype none

package upd_pkg;

  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned CapW         = 16;
  localparam int unsigned CountOutW    = 16;
  localparam int unsigned CfgAddrW     = 3;
  localparam int unsigned CfgDataW     = 32;
  localparam int unsigned QDepth       = 2;
  localparam int unsigned GrpBytes     = 3;

  localparam logic [CapW-1:0]        CapReset = 16'hFFFF;
  localparam logic [CfgAddrW-3:0]    RegCap   = 1'b0;

  localparam logic [7:0] CharNul     = 8'h00;
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharUpA     = 8'h41;
  localparam logic [7:0] CharUpF     = 8'h46;
  localparam logic [7:0] CharLoA     = 8'h61;
  localparam logic [7:0] CharLoF     = 8'h66;
  localparam logic [7:0] UpBase      = CharUpA - 8'd10;
  localparam logic [7:0] LoBase      = CharLoA - 8'd10;

  typedef enum logic [1:0] {
    PendIdle  = 2'd0,
    PendPct   = 2'd1,
    PendDigit = 2'd2
  } pend_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [1:0]                n_bytes;
    logic [GrpBytes-1:0][7:0]  bytes;
    logic                      status;
  } grp_t;

  function automatic hex_t hex_dec(logic [7:0] c);
    hex_t       h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if (c >= CharZero && c <= CharNine) begin
      d = c - CharZero;
      h.ok = 1'b1;
    end else if (c >= CharUpA && c <= CharUpF) begin
      d = c - UpBase;
      h.ok = 1'b1;
    end else if (c >= CharLoA && c <= CharLoF) begin
      d = c - LoBase;
      h.ok = 1'b1;
    end
    h.val = d[3:0];
    return h;
  endfunction

  function automatic logic [7:0] plain_char(logic [7:0] c);
    return (c == CharPlus) ? CharSpace : c;
  endfunction

  function automatic grp_t add_byte(grp_t g, logic [7:0] b);
    grp_t r;
    r = g;
    r.bytes[r.n_bytes] = b;
    r.n_bytes = r.n_bytes + 2'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/upd_front.sv @@
// Front end: accepts encoded bytes, tracks escapes and builds the byte group for each input
`default_nettype none

module upd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          in_last_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output upd_pkg::grp_t      push_grp_o
);
  import upd_pkg::*;

  pend_e      pend_q, pend_d;
  logic [7:0] digit_q, digit_d;
  logic       halted_q, halted_d;
  logic       accept;
  grp_t       grp;
  hex_t       hc, hd;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign hc         = hex_dec(in_byte_i);
  assign hd         = hex_dec(digit_q);

  always_comb begin
    pend_d   = pend_q;
    digit_d  = digit_q;
    halted_d = halted_q;
    grp      = '0;
    if (halted_q) begin
      if (in_last_i) begin
        halted_d = 1'b0;
      end
    end else if (in_byte_i == CharNul) begin
      if (pend_q != PendIdle) begin
        grp = add_byte(grp, CharPercent);
      end
      if (pend_q == PendDigit) begin
        grp = add_byte(grp, plain_char(digit_q));
      end
      grp.status = 1'b1;
      pend_d     = PendIdle;
      halted_d   = !in_last_i;
    end else begin
      unique case (pend_q)
        PendIdle: begin
          if (in_byte_i == CharPercent) begin
            pend_d = PendPct;
          end else begin
            grp = add_byte(grp, plain_char(in_byte_i));
          end
        end
        PendPct: begin
          if (hc.ok) begin
            digit_d = in_byte_i;
            pend_d  = PendDigit;
          end else begin
            grp = add_byte(grp, CharPercent);
            if (in_byte_i == CharPercent) begin
              pend_d = PendPct;
            end else begin
              grp    = add_byte(grp, plain_char(in_byte_i));
              pend_d = PendIdle;
            end
          end
        end
        PendDigit: begin
          if (hc.ok && hd.ok) begin
            grp    = add_byte(grp, {hd.val, hc.val});
            pend_d = PendIdle;
          end else begin
            grp = add_byte(grp, CharPercent);
            grp = add_byte(grp, plain_char(digit_q));
            if (in_byte_i == CharPercent) begin
              pend_d = PendPct;
            end else begin
              grp    = add_byte(grp, plain_char(in_byte_i));
              pend_d = PendIdle;
            end
          end
        end
        default: pend_d = PendIdle;
      endcase
      if (in_last_i) begin
        if (pend_d != PendIdle) begin
          grp = add_byte(grp, CharPercent);
        end
        if (pend_d == PendDigit) begin
          grp = add_byte(grp, plain_char(digit_d));
        end
        grp.status = 1'b1;
        pend_d     = PendIdle;
      end
    end
  end

  assign push_o     = accept && ((grp.n_bytes != 2'd0) || grp.status);
  assign push_grp_o = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= PendIdle;
      digit_q  <= CharNul;
      halted_q <= 1'b0;
    end else if (accept) begin
      pend_q   <= pend_d;
      digit_q  <= digit_d;
      halted_q <= halted_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/upd_queue.sv @@
// Short queue of byte groups between front end and back end
`default_nettype none

module upd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire upd_pkg::grp_t  push_grp_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output upd_pkg::grp_t       head_o
);
  import upd_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  grp_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PtrW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/upd_back.sv @@
// Back end: counts bytes against capacity, drops on overflow and drives the result register
`default_nettype none

module upd_back #(
  parameter int unsigned COUNT_BITS = upd_pkg::CountBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          empty_i,
  input  wire upd_pkg::grp_t                 head_i,
  output logic                               pop_o,
  input  wire logic [upd_pkg::CapW-1:0]      cap_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [7:0]                         out_byte_o,
  output logic                               byte_valid_o,
  output logic                               done_res_o,
  output logic                               overflow_o,
  output logic [upd_pkg::CountOutW-1:0]      decoded_count_o,
  output logic                               run_end_o
);
  import upd_pkg::*;

  localparam int unsigned CmpW = (COUNT_BITS > CapW) ? COUNT_BITS : CapW;

  logic [1:0]            slot_q, slot_d;
  logic                  ovfl_q, ovfl_d;
  logic [COUNT_BITS-1:0] total_q, total_d, total_inc;
  logic [CmpW-1:0]       total_ext, inc_ext, cap_ext;
  logic                  drop, next_drop, is_byte, last_byte, advance, emit;
  logic [7:0]            e_byte;
  logic                  e_bvalid, e_done, e_ovf, e_run_end;
  logic [CountOutW-1:0]  e_count;

  logic                  valid_q, valid_d;
  logic [7:0]            byte_q;
  logic                  bvalid_q, done_q, ovf_q, run_end_q;
  logic [CountOutW-1:0]  count_q;

  assign total_inc = total_q + COUNT_BITS'(1);
  assign total_ext = CmpW'(total_q);
  assign inc_ext   = CmpW'(total_inc);
  assign cap_ext   = CmpW'(cap_i);
  assign drop      = ovfl_q || (total_ext >= cap_ext) || (&total_q);
  assign next_drop = (inc_ext >= cap_ext) || (&total_inc);
  assign is_byte   = (slot_q < head_i.n_bytes);
  assign last_byte = (({1'b0, slot_q} + 3'd1) == {1'b0, head_i.n_bytes});
  assign advance   = !empty_i && (!valid_q || out_ready_i);

  always_comb begin
    slot_d    = slot_q;
    ovfl_d    = ovfl_q;
    total_d   = total_q;
    pop_o     = 1'b0;
    emit      = 1'b0;
    e_byte    = head_i.bytes[slot_q];
    e_bvalid  = 1'b1;
    e_done    = 1'b0;
    e_ovf     = 1'b0;
    e_count   = inc_ext[CountOutW-1:0];
    e_run_end = 1'b0;
    if (advance) begin
      if (is_byte) begin
        if (drop) begin
          ovfl_d = 1'b1;
          if (head_i.status) begin
            slot_d = head_i.n_bytes;
          end else begin
            pop_o  = 1'b1;
            slot_d = 2'd0;
          end
        end else begin
          emit      = 1'b1;
          total_d   = total_inc;
          e_run_end = !head_i.status && (last_byte || next_drop);
          if (last_byte) begin
            if (head_i.status) begin
              slot_d = slot_q + 2'd1;
            end else begin
              pop_o  = 1'b1;
              slot_d = 2'd0;
            end
          end else if (next_drop) begin
            ovfl_d = 1'b1;
            if (head_i.status) begin
              slot_d = head_i.n_bytes;
            end else begin
              pop_o  = 1'b1;
              slot_d = 2'd0;
            end
          end else begin
            slot_d = slot_q + 2'd1;
          end
        end
      end else begin
        emit      = 1'b1;
        e_byte    = CharNul;
        e_bvalid  = 1'b0;
        e_done    = 1'b1;
        e_ovf     = ovfl_q;
        e_count   = total_ext[CountOutW-1:0];
        e_run_end = 1'b1;
        ovfl_d    = 1'b0;
        total_d   = '0;
        pop_o     = 1'b1;
        slot_d    = 2'd0;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (emit) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= 2'd0;
      ovfl_q  <= 1'b0;
      total_q <= '0;
      valid_q <= 1'b0;
    end else begin
      slot_q  <= slot_d;
      ovfl_q  <= ovfl_d;
      total_q <= total_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q    <= e_byte;
      bvalid_q  <= e_bvalid;
      done_q    <= e_done;
      ovf_q     <= e_ovf;
      count_q   <= e_count;
      run_end_q <= e_run_end;
    end
  end

  assign out_valid_o     = valid_q;
  assign out_byte_o      = byte_q;
  assign byte_valid_o    = bvalid_q;
  assign done_res_o      = done_q;
  assign overflow_o      = ovf_q;
  assign decoded_count_o = count_q;
  assign run_end_o       = run_end_q;

endmodule

`default_nettype wire

@@ sv/uri_percent_decoder_core.sv @@
// Top level of the URI percent decoder: register port, front end, group queue and back end
//
//   channel  | direction | handshake                      | payload
//   ---------+-----------+--------------------------------+---------------------------------
//   input    | in        | in_valid_i / in_ready_o        | in_byte_i, in_last_i
//   result   | out       | out_valid_o / out_ready_i      | out_byte_o .. run_end_o
//   register | in        | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// An input byte is taken every cycle while the two-entry group queue has room.
// Back end waits on out_ready_i; a group whose first byte is dropped gives no byte result.
// An input with several results holds the back end until all are given, so with out_ready_i
// high the sustained rate is one byte per cycle when each byte gives at most one result.
// Reset is asynchronous and clears all control state at once; no clearing pass follows.
`default_nettype none

module uri_percent_decoder_core #(
  parameter int unsigned COUNT_BITS = upd_pkg::CountBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [7:0]                     in_byte_i,
  input  wire logic                           in_last_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [7:0]                          out_byte_o,
  output logic                                byte_valid_o,
  output logic                                done_res_o,
  output logic                                overflow_o,
  output logic [upd_pkg::CountOutW-1:0]       decoded_count_o,
  output logic                                run_end_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [upd_pkg::CfgAddrW-1:0]   paddr,
  input  wire logic [upd_pkg::CfgDataW-1:0]   pwdata,
  output logic [upd_pkg::CfgDataW-1:0]        prdata,
  output logic                                pready
);
  import upd_pkg::*;

  logic [CapW-1:0] cap_q;
  logic            cfg_wr;
  logic            push, pop, q_full, q_empty;
  grp_t            push_grp, head_grp;
  logic            out_fire, status_ok, kind_ok;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CfgAddrW-1:2] == RegCap);
  assign prdata = CfgDataW'(cap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_wr) begin
      cap_q <= pwdata[CapW-1:0];
    end
  end

  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_grp_o (push_grp)
  );

  upd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_grp_i (push_grp),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head_grp)
  );

  upd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (q_empty),
    .head_i          (head_grp),
    .pop_o           (pop),
    .cap_i           (cap_q),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .done_res_o      (done_res_o),
    .overflow_o      (overflow_o),
    .decoded_count_o (decoded_count_o),
    .run_end_o       (run_end_o)
  );

  assign out_fire  = out_valid_o && out_ready_i;
  assign status_ok = run_end_o && !byte_valid_o;
  assign kind_ok   = (byte_valid_o != done_res_o) && !(byte_valid_o && overflow_o);

`include "uri_percent_decoder_core_assert.svh"

  `UPD_ASSERT_SAME(a_status_ends_run, out_valid_o && done_res_o, status_ok, "bad status result")
  `UPD_ASSERT_SAME(a_byte_kind, out_valid_o, kind_ok, "malformed result kind")
  `UPD_ASSERT_NEXT(a_run_continues, out_fire && !run_end_o, out_valid_o, "gap inside one run")

endmodule

`default_nettype wire
